### hw/rtl/rdwc_pkg.sv
// Package for the radio duty window controller.
// Holds the event, status, radio-state and wake codes plus the state and config structs.
// No dependencies.
package rdwc_pkg;

  localparam int TIMER_W = 24;
  localparam int TOTAL_W = 48;
  localparam int COUNT_W = 32;

  localparam logic [TOTAL_W-1:0] TOTAL_MAX = {TOTAL_W{1'b1}};

  typedef logic [2:0] func_t;
  localparam func_t FN_TICK  = 3'd0;
  localparam func_t FN_INIT  = 3'd1;
  localparam func_t FN_CONN  = 3'd2;
  localparam func_t FN_LOCAL = 3'd3;
  localparam func_t FN_RESET = 3'd4;

  typedef logic [2:0] status_t;
  localparam status_t ST_OK      = 3'd0;
  localparam status_t ST_INVALID = 3'd1;
  localparam status_t ST_NOINIT  = 3'd2;
  localparam status_t ST_BUSY    = 3'd3;
  localparam status_t ST_UNSUP   = 3'd4;
  localparam status_t ST_ALREADY = 3'd5;

  typedef logic [1:0] rstate_t;
  localparam rstate_t RS_STOPPED = 2'd0;
  localparam rstate_t RS_CONT    = 2'd1;
  localparam rstate_t RS_WINDOW  = 2'd2;

  typedef logic [1:0] mode_t;
  localparam mode_t MODE_OFF  = 2'd0;
  localparam mode_t MODE_CONT = 2'd1;
  localparam mode_t MODE_WIN  = 2'd2;
  localparam mode_t MODE_BAD  = 2'd3;

  typedef logic [1:0] wake_t;
  localparam wake_t WK_BOOT  = 2'd0;
  localparam wake_t WK_CONN  = 2'd1;
  localparam wake_t WK_TIMER = 2'd2;
  localparam wake_t WK_LOCAL = 2'd3;

  localparam int ARM_CLOSE  = 0;
  localparam int ARM_PERIOD = 1;

  typedef logic [1:0] cfg_idx_t;
  localparam cfg_idx_t CFG_MODE   = 2'd0;
  localparam cfg_idx_t CFG_WINDOW = 2'd1;
  localparam cfg_idx_t CFG_PERIOD = 2'd2;

  localparam logic [TIMER_W-1:0] WINDOW_RST = 24'd100;
  localparam logic [TIMER_W-1:0] PERIOD_RST = 24'd1000;

  typedef struct packed {
    mode_t               radio_mode;
    logic [TIMER_W-1:0]  window_ms;
    logic [TIMER_W-1:0]  period_ms;
  } cfg_t;

  typedef struct packed {
    logic                ready;
    logic                online;
    rstate_t             radio_state;
    logic                window_flag;
    logic                radio_on;
    logic                active_flag;
    logic [TOTAL_W-1:0]  radio_total;
    logic [TOTAL_W-1:0]  active_total;
    logic [COUNT_W-1:0]  window_counter;
    wake_t               wake_cause;
    logic [TIMER_W-1:0]  close_timer;
    logic [TIMER_W-1:0]  period_timer;
    logic [1:0]          timer_armed;
  } state_t;

  localparam state_t STATE_CLEAR = '{
    ready:          1'b0,
    online:         1'b0,
    radio_state:    RS_STOPPED,
    window_flag:    1'b0,
    radio_on:       1'b0,
    active_flag:    1'b0,
    radio_total:    '0,
    active_total:   '0,
    window_counter: '0,
    wake_cause:     WK_BOOT,
    close_timer:    '0,
    period_timer:   '0,
    timer_armed:    2'b00
  };

endpackage

### hw/rtl/rdwc_step.sv
// Next-state and status logic for one event of the radio duty window controller.
// Purely combinational; depends on rdwc_pkg.
module rdwc_step import rdwc_pkg::*; #(
  parameter int MIN_WINDOW_MS = 10,
  parameter int MAX_WINDOW_MS = 10000,
  parameter int MIN_PERIOD_MS = 100,
  parameter int MAX_PERIOD_MS = 3600000
) (
  input  state_t  cur,
  input  cfg_t    cfg,
  input  func_t   func,
  input  logic    want_online,
  input  logic    lease_active,
  input  logic    workspace_free,
  output state_t  nxt,
  output status_t status
);

  localparam logic [TIMER_W-1:0] MIN_W = TIMER_W'(MIN_WINDOW_MS);
  localparam logic [TIMER_W-1:0] MAX_W = TIMER_W'(MAX_WINDOW_MS);
  localparam logic [TIMER_W-1:0] MIN_P = TIMER_W'(MIN_PERIOD_MS);
  localparam logic [TIMER_W-1:0] MAX_P = TIMER_W'(MAX_PERIOD_MS);

  // Caller guarantees no window is open and mode is windowed.
  function automatic state_t open_window(input state_t s_in, input wake_t cause,
                                         input logic [TIMER_W-1:0] win);
    state_t s;
    s = s_in;
    s.radio_on               = 1'b1;
    s.radio_state            = RS_WINDOW;
    s.window_flag            = 1'b1;
    s.window_counter         = s.window_counter + COUNT_W'(1);
    s.wake_cause             = cause;
    s.close_timer            = win;
    s.timer_armed[ARM_CLOSE] = 1'b1;
    return s;
  endfunction

  logic    cf;
  logic    pf;
  logic    bad_win;
  state_t  s;
  status_t st;

  assign bad_win = (cfg.window_ms == '0) || (cfg.period_ms == '0) ||
                   (cfg.window_ms >= cfg.period_ms) ||
                   (cfg.window_ms < MIN_W) || (cfg.window_ms > MAX_W) ||
                   (cfg.period_ms < MIN_P) || (cfg.period_ms > MAX_P);

  always_comb begin
    s  = cur;
    st = ST_OK;
    cf = 1'b0;
    pf = 1'b0;
    unique case (func)
      FN_TICK: begin
        if (s.active_flag && s.active_total != TOTAL_MAX) begin
          s.active_total = s.active_total + TOTAL_W'(1);
        end
        if (s.radio_on && s.radio_total != TOTAL_MAX) begin
          s.radio_total = s.radio_total + TOTAL_W'(1);
        end
        if (s.timer_armed[ARM_CLOSE]) begin
          if (s.close_timer <= TIMER_W'(1)) begin
            cf = 1'b1;
            s.timer_armed[ARM_CLOSE] = 1'b0;
            s.close_timer = '0;
          end else begin
            s.close_timer = s.close_timer - TIMER_W'(1);
          end
        end
        if (s.timer_armed[ARM_PERIOD]) begin
          if (s.period_timer <= TIMER_W'(1)) begin
            pf = 1'b1;
            s.timer_armed[ARM_PERIOD] = 1'b0;
            s.period_timer = '0;
          end else begin
            s.period_timer = s.period_timer - TIMER_W'(1);
          end
        end
        if (cf) begin
          if (s.window_flag) begin
            if (s.radio_state == RS_WINDOW) begin
              s.radio_on    = 1'b0;
              s.radio_state = RS_STOPPED;
            end
            s.window_flag  = 1'b0;
            s.timer_armed  = 2'b00;
            s.close_timer  = '0;
            s.period_timer = '0;
          end
          if (cfg.radio_mode == MODE_WIN && !s.online) begin
            s.period_timer            = cfg.period_ms;
            s.timer_armed[ARM_PERIOD] = 1'b1;
          end
        end else if (pf) begin
          if (s.ready && cfg.radio_mode == MODE_WIN && !s.online && !s.window_flag) begin
            s = open_window(s, WK_TIMER, cfg.window_ms);
          end
        end
      end
      FN_INIT: begin
        if (cfg.radio_mode == MODE_BAD) begin
          st = ST_INVALID;
        end else if (cfg.radio_mode == MODE_WIN && bad_win) begin
          st = ST_INVALID;
        end else if (s.ready) begin
          st = ST_ALREADY;
        end else begin
          s.online         = 1'b0;
          s.radio_state    = RS_STOPPED;
          s.window_flag    = 1'b0;
          s.radio_on       = 1'b0;
          s.active_flag    = 1'b1;
          s.radio_total    = '0;
          s.active_total   = '0;
          s.window_counter = '0;
          s.wake_cause     = WK_BOOT;
          s.ready          = 1'b1;
        end
      end
      FN_CONN: begin
        if (!s.ready) begin
          st = ST_NOINIT;
        end else if (!want_online && !workspace_free) begin
          st = ST_BUSY;
        end else begin
          s.online       = want_online;
          s.wake_cause   = WK_CONN;
          s.active_flag  = want_online | lease_active;
          s.timer_armed  = 2'b00;
          s.close_timer  = '0;
          s.period_timer = '0;
          s.window_flag  = 1'b0;
          if (want_online) begin
            s.radio_on    = 1'b0;
            s.radio_state = RS_STOPPED;
          end else begin
            unique case (cfg.radio_mode)
              MODE_OFF: begin
                s.radio_on    = 1'b0;
                s.radio_state = RS_STOPPED;
              end
              MODE_CONT: begin
                s.radio_on    = 1'b1;
                s.radio_state = RS_CONT;
              end
              MODE_WIN: begin
                s.radio_on    = 1'b0;
                s.radio_state = RS_STOPPED;
                s = open_window(s, WK_CONN, cfg.window_ms);
              end
              default: begin
                // bad mode: keep side effects, roll back connectivity
                st       = ST_INVALID;
                s.online = cur.online;
              end
            endcase
          end
        end
      end
      FN_LOCAL: begin
        if (!s.ready) begin
          st = ST_NOINIT;
        end else if (cfg.radio_mode != MODE_WIN) begin
          st = ST_UNSUP;
        end else if (s.window_flag) begin
          st = ST_ALREADY;
        end else begin
          s = open_window(s, WK_LOCAL, cfg.window_ms);
        end
      end
      FN_RESET: begin
        s = STATE_CLEAR;
      end
      default: begin
        st = ST_INVALID;
      end
    endcase
    nxt    = s;
    status = st;
  end

endmodule

### hw/rtl/radio_duty_window_controller_unit.sv
// Top level of the radio duty window controller.
// Holds config, controller state and the result register; uses rdwc_pkg and rdwc_step.
//
// Usage:
//   Input channel (in_valid/in_ready) carries one event per transaction: tick,
//   init, connectivity change, local wake event or controller reset, with the
//   lease and workspace bits alongside.
//   Output channel (out_valid/out_ready) returns one result per event: a status
//   and a snapshot of totals, window count, wake cause and flags after the event.
//   Config channel (cfg_valid/cfg_ready, cfg_index, cfg_data) writes radio mode,
//   window length and period; it is always ready and registers are used live.
// Timing:
//   out_valid rises in the cycle after the input transaction. The state update
//   is a single pass of next-state logic (two 48-bit saturating increments,
//   two 24-bit down counters and the window checks) into the state registers.
//   One event per cycle is sustained as long as the receiver takes results.
// Reset and stalls:
//   rst_n clears the state, the result register and loads register defaults.
//   While a result waits, in_ready follows out_ready, so the next event is taken
//   in the same cycle the waiting result leaves.
module radio_duty_window_controller_unit import rdwc_pkg::*; #(
  parameter int MIN_WINDOW_MS = 10,
  parameter int MAX_WINDOW_MS = 10000,
  parameter int MIN_PERIOD_MS = 100,
  parameter int MAX_PERIOD_MS = 3600000
) (
  input  logic                clk,
  input  logic                rst_n,

  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [1:0]          cfg_index,
  input  logic [TIMER_W-1:0]  cfg_data,

  input  logic                in_valid,
  output logic                in_ready,
  input  logic [2:0]          in_func,
  input  logic                in_want_online,
  input  logic                in_lease_active,
  input  logic                in_workspace_free,

  output logic                out_valid,
  input  logic                out_ready,
  output logic [2:0]          out_status,
  output logic [TOTAL_W-1:0]  out_active_total_ms,
  output logic [TOTAL_W-1:0]  out_radio_total_ms,
  output logic [COUNT_W-1:0]  out_windows_opened,
  output logic [1:0]          out_last_wake,
  output logic                out_radio_is_on,
  output logic                out_window_open,
  output logic                out_is_online,
  output logic                out_is_ready
);

  cfg_t    cfg_r;
  state_t  state_r;
  state_t  state_nxt;
  status_t status_r;
  status_t status_nxt;
  logic    out_valid_r;
  logic    in_fire;
  logic    cfg_fire;

  assign cfg_ready = 1'b1;
  assign cfg_fire  = cfg_valid & cfg_ready;
  assign in_ready  = ~out_valid_r | out_ready;
  assign in_fire   = in_valid & in_ready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.radio_mode <= MODE_OFF;
      cfg_r.window_ms  <= WINDOW_RST;
      cfg_r.period_ms  <= PERIOD_RST;
    end else if (cfg_fire) begin
      unique case (cfg_index)
        CFG_MODE:   cfg_r.radio_mode <= cfg_data[1:0];
        CFG_WINDOW: cfg_r.window_ms  <= cfg_data;
        CFG_PERIOD: cfg_r.period_ms  <= cfg_data;
        default:    ;
      endcase
    end
  end

  rdwc_step #(
    .MIN_WINDOW_MS (MIN_WINDOW_MS),
    .MAX_WINDOW_MS (MAX_WINDOW_MS),
    .MIN_PERIOD_MS (MIN_PERIOD_MS),
    .MAX_PERIOD_MS (MAX_PERIOD_MS)
  ) u_step (
    .cur            (state_r),
    .cfg            (cfg_r),
    .func           (in_func),
    .want_online    (in_want_online),
    .lease_active   (in_lease_active),
    .workspace_free (in_workspace_free),
    .nxt            (state_nxt),
    .status         (status_nxt)
  );

  // State only moves on an input transaction, which needs the result slot free,
  // so the state registers double as the snapshot part of the result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= STATE_CLEAR;
      out_valid_r <= 1'b0;
    end else begin
      if (in_fire) begin
        state_r     <= state_nxt;
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      status_r <= ST_OK;
    end else if (in_fire) begin
      status_r <= status_nxt;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_status          = status_r;
  assign out_active_total_ms = state_r.active_total;
  assign out_radio_total_ms  = state_r.radio_total;
  assign out_windows_opened  = state_r.window_counter;
  assign out_last_wake       = state_r.wake_cause;
  assign out_radio_is_on     = state_r.radio_on;
  assign out_window_open     = state_r.window_flag;
  assign out_is_online       = state_r.online;
  assign out_is_ready        = state_r.ready;

  a_window_radio: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.window_flag |-> state_r.radio_on && state_r.radio_state == RS_WINDOW)
    else $error("open window without radio on");

  a_close_armed: assert property (@(posedge clk) disable iff (!rst_n)
    state_r.timer_armed[ARM_CLOSE] == state_r.window_flag)
    else $error("close timer arming out of step with window");

  a_idle_when_uninit: assert property (@(posedge clk) disable iff (!rst_n)
    !state_r.ready |-> !state_r.window_flag && !state_r.radio_on && !state_r.active_flag)
    else $error("activity while not initialized");

  a_count_step: assert property (@(posedge clk) disable iff (!rst_n)
    in_fire && in_func != FN_RESET && in_func != FN_INIT |=>
      state_r.window_counter == $past(state_r.window_counter) ||
      state_r.window_counter == $past(state_r.window_counter) + COUNT_W'(1))
    else $error("window count jumped");

endmodule

### verif/tb_top.sv
// Self-checking testbench for radio_duty_window_controller_unit: directed events, then
// randomized batches with per-transaction idling on both channels, checked against a
// cycle-free model of the controller. Depends on rdwc_pkg and the controller RTL only.
module tb_top import rdwc_pkg::*; ();

  timeunit 1ns;
  timeprecision 1ps;

  localparam int MIN_WINDOW = 10;
  localparam int MAX_WINDOW = 10000;
  localparam int MIN_PERIOD = 100;
  localparam int MAX_PERIOD = 3600000;
  localparam int RANDOM_ITEMS = 400;
  localparam int STALL_LIMIT = 400;

  localparam func_t FN_UNUSED_A = 3'd5;
  localparam func_t FN_UNUSED_B = 3'd6;
  localparam func_t FN_UNUSED_C = 3'd7;
  localparam cfg_idx_t CFG_SPARE = 2'd3;
  localparam logic [TIMER_W-1:0] TIMER_ALL = {TIMER_W{1'b1}};

  typedef struct packed {
    func_t fn;
    logic  want;
    logic  lease;
    logic  ws_free;
  } ctl_event_t;

  typedef struct packed {
    status_t            status;
    logic [TOTAL_W-1:0] active_total;
    logic [TOTAL_W-1:0] radio_total;
    logic [COUNT_W-1:0] windows;
    wake_t              wake;
    logic               radio_on;
    logic               window_open;
    logic               online;
    logic               ready;
  } snap_t;

  logic clk;
  logic rst_n = 1'b0;

  logic               cfg_valid = 1'b0;
  logic               cfg_ready;
  logic [1:0]         cfg_index = '0;
  logic [TIMER_W-1:0] cfg_data = '0;

  logic       in_valid = 1'b0;
  logic       in_ready;
  logic [2:0] in_func = '0;
  logic       in_want_online = 1'b0;
  logic       in_lease_active = 1'b0;
  logic       in_workspace_free = 1'b0;

  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [2:0]         out_status;
  logic [TOTAL_W-1:0] out_active_total_ms;
  logic [TOTAL_W-1:0] out_radio_total_ms;
  logic [COUNT_W-1:0] out_windows_opened;
  logic [1:0]         out_last_wake;
  logic               out_radio_is_on;
  logic               out_window_open;
  logic               out_is_online;
  logic               out_is_ready;

  ctl_event_t pending_events[$];
  snap_t      snapshots_due[$];
  state_t     ctl_state = STATE_CLEAR;
  cfg_t       live_cfg = '{MODE_OFF, WINDOW_RST, PERIOD_RST};

  logic in_took = 1'b0;
  logic out_took = 1'b0;
  int   in_wait = 0;
  int   out_wait = 0;
  int   in_calm = 0;
  int   out_calm = 0;
  int   stall_cycles = 0;
  int   errors = 0;

  radio_duty_window_controller_unit u_top (
    .clk                 (clk),
    .rst_n               (rst_n),
    .cfg_valid           (cfg_valid),
    .cfg_ready           (cfg_ready),
    .cfg_index           (cfg_index),
    .cfg_data            (cfg_data),
    .in_valid            (in_valid),
    .in_ready            (in_ready),
    .in_func             (in_func),
    .in_want_online      (in_want_online),
    .in_lease_active     (in_lease_active),
    .in_workspace_free   (in_workspace_free),
    .out_valid           (out_valid),
    .out_ready           (out_ready),
    .out_status          (out_status),
    .out_active_total_ms (out_active_total_ms),
    .out_radio_total_ms  (out_radio_total_ms),
    .out_windows_opened  (out_windows_opened),
    .out_last_wake       (out_last_wake),
    .out_radio_is_on     (out_radio_is_on),
    .out_window_open     (out_window_open),
    .out_is_online       (out_is_online),
    .out_is_ready        (out_is_ready)
  );

  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  function automatic status_t open_window(input wake_t cause);
    if (ctl_state.window_flag) return ST_ALREADY;
    if (live_cfg.radio_mode != MODE_WIN) return ST_UNSUP;
    ctl_state.radio_on = 1'b1;
    ctl_state.radio_state = RS_WINDOW;
    ctl_state.window_flag = 1'b1;
    ctl_state.window_counter = ctl_state.window_counter + COUNT_W'(1);
    ctl_state.wake_cause = cause;
    ctl_state.close_timer = live_cfg.window_ms;
    ctl_state.timer_armed[ARM_CLOSE] = 1'b1;
    return ST_OK;
  endfunction

  function automatic snap_t apply_event(input ctl_event_t ev);
    snap_t   snap;
    status_t st;
    logic    close_hit;
    logic    period_hit;
    logic    prior_online;
    st = ST_OK;
    close_hit = 1'b0;
    period_hit = 1'b0;
    case (ev.fn)
      FN_TICK: begin
        if (ctl_state.active_flag && ctl_state.active_total != TOTAL_MAX)
          ctl_state.active_total = ctl_state.active_total + TOTAL_W'(1);
        if (ctl_state.radio_on && ctl_state.radio_total != TOTAL_MAX)
          ctl_state.radio_total = ctl_state.radio_total + TOTAL_W'(1);
        if (ctl_state.timer_armed[ARM_CLOSE]) begin
          if (ctl_state.close_timer <= TIMER_W'(1)) begin
            close_hit = 1'b1;
            ctl_state.timer_armed[ARM_CLOSE] = 1'b0;
            ctl_state.close_timer = '0;
          end else begin
            ctl_state.close_timer = ctl_state.close_timer - TIMER_W'(1);
          end
        end
        if (ctl_state.timer_armed[ARM_PERIOD]) begin
          if (ctl_state.period_timer <= TIMER_W'(1)) begin
            period_hit = 1'b1;
            ctl_state.timer_armed[ARM_PERIOD] = 1'b0;
            ctl_state.period_timer = '0;
          end else begin
            ctl_state.period_timer = ctl_state.period_timer - TIMER_W'(1);
          end
        end
        // close wins when both expire together
        if (close_hit) begin
          if (ctl_state.window_flag) begin
            if (ctl_state.radio_state == RS_WINDOW) begin
              ctl_state.radio_on = 1'b0;
              ctl_state.radio_state = RS_STOPPED;
            end
            ctl_state.window_flag = 1'b0;
            ctl_state.timer_armed = '0;
            ctl_state.close_timer = '0;
            ctl_state.period_timer = '0;
          end
          if (live_cfg.radio_mode == MODE_WIN && !ctl_state.online) begin
            ctl_state.period_timer = live_cfg.period_ms;
            ctl_state.timer_armed[ARM_PERIOD] = 1'b1;
          end
        end else if (period_hit) begin
          if (ctl_state.ready && live_cfg.radio_mode == MODE_WIN && !ctl_state.online &&
              !ctl_state.window_flag)
            void'(open_window(WK_TIMER));
        end
      end
      FN_INIT: begin
        if (live_cfg.radio_mode == MODE_BAD) begin
          st = ST_INVALID;
        end else if (live_cfg.radio_mode == MODE_WIN &&
                     (live_cfg.window_ms == 0 || live_cfg.period_ms == 0 ||
                      live_cfg.window_ms >= live_cfg.period_ms ||
                      live_cfg.window_ms < MIN_WINDOW || live_cfg.window_ms > MAX_WINDOW ||
                      live_cfg.period_ms < MIN_PERIOD || live_cfg.period_ms > MAX_PERIOD)) begin
          st = ST_INVALID;
        end else if (ctl_state.ready) begin
          st = ST_ALREADY;
        end else begin
          ctl_state.online = 1'b0;
          ctl_state.radio_state = RS_STOPPED;
          ctl_state.window_flag = 1'b0;
          ctl_state.radio_on = 1'b0;
          ctl_state.active_flag = 1'b1;
          ctl_state.radio_total = '0;
          ctl_state.active_total = '0;
          ctl_state.window_counter = '0;
          ctl_state.wake_cause = WK_BOOT;
          ctl_state.ready = 1'b1;
        end
      end
      FN_CONN: begin
        if (!ctl_state.ready) begin
          st = ST_NOINIT;
        end else if (!ev.want && !ev.ws_free) begin
          st = ST_BUSY;
        end else begin
          prior_online = ctl_state.online;
          ctl_state.online = ev.want;
          ctl_state.wake_cause = WK_CONN;
          ctl_state.active_flag = ev.want || ev.lease;
          ctl_state.timer_armed = '0;
          ctl_state.close_timer = '0;
          ctl_state.period_timer = '0;
          ctl_state.window_flag = 1'b0;
          if (ctl_state.online) begin
            ctl_state.radio_on = 1'b0;
            ctl_state.radio_state = RS_STOPPED;
          end else begin
            case (live_cfg.radio_mode)
              MODE_OFF: begin
                ctl_state.radio_on = 1'b0;
                ctl_state.radio_state = RS_STOPPED;
              end
              MODE_CONT: begin
                ctl_state.radio_on = 1'b1;
                ctl_state.radio_state = RS_CONT;
              end
              MODE_WIN: begin
                ctl_state.radio_on = 1'b0;
                ctl_state.radio_state = RS_STOPPED;
                st = open_window(WK_CONN);
              end
              default: st = ST_INVALID;
            endcase
          end
          // invalid mode rolls back only the policy bit
          if (st != ST_OK) ctl_state.online = prior_online;
        end
      end
      FN_LOCAL: begin
        if (!ctl_state.ready) st = ST_NOINIT;
        else if (live_cfg.radio_mode != MODE_WIN) st = ST_UNSUP;
        else st = open_window(WK_LOCAL);
      end
      FN_RESET: ctl_state = STATE_CLEAR;
      default: st = ST_INVALID;
    endcase
    snap.status = st;
    snap.active_total = ctl_state.active_total;
    snap.radio_total = ctl_state.radio_total;
    snap.windows = ctl_state.window_counter;
    snap.wake = ctl_state.wake_cause;
    snap.radio_on = ctl_state.radio_on;
    snap.window_open = ctl_state.window_flag;
    snap.online = ctl_state.online;
    snap.ready = ctl_state.ready;
    return snap;
  endfunction

  function automatic int draw_gap(inout int calm);
    if (calm > 0) begin
      calm--;
      return 0;
    end
    if ($urandom_range(0, 9) == 0) calm = $urandom_range(8, 40);
    return $urandom_range(0, 18);
  endfunction

  function automatic ctl_event_t random_event();
    ctl_event_t ev;
    int         pick;
    pick = $urandom_range(0, 99);
    ev.want = ($urandom_range(0, 9) < 4);
    ev.lease = 1'($urandom_range(0, 1));
    ev.ws_free = ($urandom_range(0, 3) != 0);
    if (pick < 52) ev.fn = FN_TICK;
    else if (pick < 66) ev.fn = FN_CONN;
    else if (pick < 80) ev.fn = FN_LOCAL;
    else if (pick < 90) ev.fn = FN_INIT;
    else if (pick < 94) ev.fn = FN_RESET;
    else ev.fn = func_t'($urandom_range(FN_UNUSED_A, FN_UNUSED_C));
    return ev;
  endfunction

  task automatic check_field(input string field, input logic [TOTAL_W-1:0] want_v,
                             input logic [TOTAL_W-1:0] got_v);
    if (got_v !== want_v) begin
      errors++;
      $display("%0t ns: %s mismatch, expected %0h, got %0h", $time, field, want_v, got_v);
    end
  endtask

  task automatic queue_event(input func_t fn, input logic want, input logic lease,
                             input logic ws_free);
    pending_events.push_back('{fn, want, lease, ws_free});
  endtask

  // starts at a falling edge, returns right after a rising edge
  task automatic write_reg(input cfg_idx_t idx, input logic [TIMER_W-1:0] val);
    @(negedge clk);
    cfg_valid <= 1'b1;
    cfg_index <= idx;
    cfg_data <= val;
    do @(posedge clk); while (!cfg_ready);
    @(negedge clk);
    cfg_valid <= 1'b0;
    @(posedge clk);
  endtask

  task automatic drain();
    do @(posedge clk);
    while (pending_events.size() != 0 || in_valid || snapshots_due.size() != 0);
  endtask

  // input driver
  always @(negedge clk) begin
    ctl_event_t nxt;
    if (!(in_valid && !in_took)) begin
      if (in_wait > 0) begin
        in_wait--;
        in_valid <= 1'b0;
      end else if (pending_events.size() != 0) begin
        nxt = pending_events.pop_front();
        in_func <= nxt.fn;
        in_want_online <= nxt.want;
        in_lease_active <= nxt.lease;
        in_workspace_free <= nxt.ws_free;
        in_valid <= 1'b1;
        in_wait = draw_gap(in_calm);
      end else begin
        in_valid <= 1'b0;
      end
    end
  end

  // result backpressure, stall counted only while a result is waiting
  always @(negedge clk) begin
    if (out_took) out_wait = draw_gap(out_calm);
    if (out_wait > 0) begin
      out_ready <= 1'b0;
      if (out_valid) out_wait--;
    end else begin
      out_ready <= 1'b1;
    end
  end

  // monitor, model update and watchdog
  always @(posedge clk) begin
    snap_t due;
    in_took <= in_valid && in_ready;
    out_took <= out_valid && out_ready;
    if (!rst_n) begin
      ctl_state = STATE_CLEAR;
      live_cfg = '{MODE_OFF, WINDOW_RST, PERIOD_RST};
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          CFG_MODE:   live_cfg.radio_mode = cfg_data[1:0];
          CFG_WINDOW: live_cfg.window_ms = cfg_data;
          CFG_PERIOD: live_cfg.period_ms = cfg_data;
          default: ;
        endcase
      end
      if (out_valid && out_ready) begin
        if (snapshots_due.size() == 0) begin
          errors++;
          $display("%0t ns: result transaction with nothing expected, status %0d",
                   $time, out_status);
        end else begin
          due = snapshots_due.pop_front();
          check_field("status", TOTAL_W'(due.status), TOTAL_W'(out_status));
          check_field("active_total_ms", due.active_total, out_active_total_ms);
          check_field("radio_total_ms", due.radio_total, out_radio_total_ms);
          check_field("windows_opened", TOTAL_W'(due.windows), TOTAL_W'(out_windows_opened));
          check_field("last_wake", TOTAL_W'(due.wake), TOTAL_W'(out_last_wake));
          check_field("radio_is_on", TOTAL_W'(due.radio_on), TOTAL_W'(out_radio_is_on));
          check_field("window_open", TOTAL_W'(due.window_open), TOTAL_W'(out_window_open));
          check_field("is_online", TOTAL_W'(due.online), TOTAL_W'(out_is_online));
          check_field("is_ready", TOTAL_W'(due.ready), TOTAL_W'(out_is_ready));
        end
      end
      if (in_valid && in_ready)
        snapshots_due.push_back(apply_event('{in_func, in_want_online, in_lease_active,
                                              in_workspace_free}));
    end
    if ((in_valid && in_ready) || (out_valid && out_ready) || (cfg_valid && cfg_ready))
      stall_cycles = 0;
    else
      stall_cycles++;
    if (stall_cycles >= STALL_LIMIT) begin
      $display("%0t ns: no transaction for %0d cycles", $time, stall_cycles);
      $display("[FAIL] regression broken");
      $finish;
    end
  end

  initial begin
    int                 random_sent;
    int                 batch;
    int                 pick;
    mode_t              mode;
    logic [TIMER_W-1:0] win;
    logic [TIMER_W-1:0] per;

    repeat (7) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // before init, unknown codes, init twice, busy workspace, low energy without lease
    queue_event(FN_CONN, 1'b1, 1'b1, 1'b1);
    queue_event(FN_LOCAL, 1'b0, 1'b0, 1'b1);
    queue_event(FN_UNUSED_A, 1'b1, 1'b0, 1'b0);
    queue_event(FN_UNUSED_B, 1'b0, 1'b1, 1'b0);
    queue_event(FN_UNUSED_C, 1'b1, 1'b1, 1'b1);
    queue_event(FN_TICK, 1'b0, 1'b0, 1'b0);
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    queue_event(FN_INIT, 1'b1, 1'b1, 1'b1);
    queue_event(FN_LOCAL, 1'b0, 1'b0, 1'b1);
    queue_event(FN_CONN, 1'b0, 1'b1, 1'b0);
    queue_event(FN_CONN, 1'b0, 1'b0, 1'b1);
    drain();

    // invalid mode after init
    write_reg(CFG_MODE, TIMER_W'(MODE_BAD));
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    queue_event(FN_CONN, 1'b0, 1'b1, 1'b1);
    queue_event(FN_CONN, 1'b1, 1'b0, 1'b0);
    drain();

    // windowed init bounds
    write_reg(CFG_SPARE, TIMER_ALL);
    write_reg(CFG_MODE, TIMER_W'(MODE_WIN));
    write_reg(CFG_WINDOW, '0);
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    drain();
    write_reg(CFG_WINDOW, TIMER_W'(MAX_WINDOW));
    write_reg(CFG_PERIOD, TIMER_W'(MAX_WINDOW));
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    drain();
    write_reg(CFG_WINDOW, TIMER_W'(MIN_WINDOW - 1));
    write_reg(CFG_PERIOD, TIMER_W'(MIN_PERIOD));
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    drain();
    write_reg(CFG_WINDOW, TIMER_W'(MAX_WINDOW + 1));
    write_reg(CFG_PERIOD, TIMER_W'(MAX_PERIOD));
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    drain();
    write_reg(CFG_WINDOW, TIMER_W'(MIN_WINDOW));
    write_reg(CFG_PERIOD, TIMER_W'(MIN_PERIOD - 1));
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    drain();
    write_reg(CFG_WINDOW, TIMER_W'(MAX_WINDOW));
    write_reg(CFG_PERIOD, TIMER_W'(MAX_PERIOD + 1));
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    drain();
    write_reg(CFG_PERIOD, TIMER_W'(MAX_PERIOD));
    queue_event(FN_RESET, 1'b1, 1'b1, 1'b1);
    queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
    queue_event(FN_CONN, 1'b0, 1'b1, 1'b1);
    queue_event(FN_LOCAL, 1'b0, 1'b0, 1'b1);
    drain();

    // random batches: re-init under a legal windowed setting, then switch to the run setting
    random_sent = 0;
    while (random_sent < RANDOM_ITEMS) begin
      write_reg(CFG_MODE, TIMER_W'(MODE_WIN));
      write_reg(CFG_WINDOW, TIMER_W'(MIN_WINDOW));
      write_reg(CFG_PERIOD, TIMER_W'(MIN_PERIOD));
      queue_event(FN_INIT, 1'b0, 1'b0, 1'b1);
      drain();

      pick = $urandom_range(0, 19);
      win = TIMER_W'($urandom);
      per = TIMER_W'($urandom);
      if (pick < 10) begin
        mode = MODE_WIN;
        win = TIMER_W'($urandom_range(0, 4));
        per = TIMER_W'($urandom_range(0, 6));
      end else if (pick < 12) begin
        mode = MODE_OFF;
      end else if (pick < 14) begin
        mode = MODE_CONT;
      end else if (pick < 16) begin
        mode = MODE_BAD;
      end else if (pick < 17) begin
        mode = MODE_WIN;
        win = TIMER_ALL;
        per = TIMER_ALL;
      end else begin
        mode = MODE_WIN;
        win = TIMER_W'($urandom_range(MIN_WINDOW, MIN_WINDOW + 4));
        per = TIMER_W'($urandom_range(15, 40));
      end
      write_reg(CFG_MODE, TIMER_W'(mode));
      write_reg(CFG_WINDOW, win);
      write_reg(CFG_PERIOD, per);

      batch = $urandom_range(10, 22);
      repeat (batch) pending_events.push_back(random_event());
      random_sent += batch;
      drain();
    end

    repeat (4) @(posedge clk);
    if (errors == 0)
      $display("[ OK ] regression clean");
    else
      $display("[FAIL] regression broken");
    $finish;
  end

endmodule
